// ===== design/tga_image_stream_decoder_macros.svh =====
// Assertion macros for the TGA stream decoder.
// No dependencies.
`ifndef TGA_IMAGE_STREAM_DECODER_MACROS_SVH
`define TGA_IMAGE_STREAM_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define TGA_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("tga assertion failed");
`define TGA_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("tga assertion failed");
`else
`define TGA_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define TGA_ASSERT_NXT(lbl, clk, rst_n, a, c)
`endif
`endif

// ===== design/tga_pkg.sv =====
// Shared types and constants for the TGA stream decoder.
// No dependencies.
`timescale 1ns / 1ps
package tga_pkg;
    localparam int QueueDepth = 4;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_BADTYP = 2'd2;
    localparam logic [1:0] KIND_BADBPP = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  repeat_count;
        logic [31:0] pixel_index;
        logic        image_last;
        logic [15:0] image_width;
        logic [15:0] image_height;
    } t_result;
endpackage

// ===== design/tga_front.sv =====
// Front end: header parse, skip, packet and pixel decode; one byte per cycle while i_valid is high.
// Depends on tga_pkg.
`timescale 1ns / 1ps
`include "tga_image_stream_decoder_macros.svh"
module tga_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_data_byte,
    input  logic              i_file_start,
    output logic              o_valid,
    output tga_pkg::t_result  o_result
);
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_SKIP   = 3'd1;
    localparam logic [2:0] PH_PACKET = 3'd2;
    localparam logic [2:0] PH_PIXEL  = 3'd3;
    localparam logic [2:0] PH_IDLE   = 3'd4;

    logic [2:0]  r_phase, n_phase;
    logic [4:0]  r_hcnt, n_hcnt;
    logic [7:0]  r_idlen, n_idlen, r_mapp, n_mapp, r_type, n_type;
    logic [15:0] r_mcnt, n_mcnt;
    logic [7:0]  r_mbits, n_mbits;
    logic [15:0] r_w, n_w, r_h, n_h;
    logic [7:0]  r_bpp, n_bpp;
    logic [21:0] r_skip, n_skip;
    logic [23:0] r_pix, n_pix;
    logic [1:0]  r_bpos, n_bpos;
    logic [6:0]  r_prem, n_prem;
    logic        r_isrun, n_isrun;
    logic [31:0] r_done, n_done;
    logic [31:0] r_total, n_total;
    logic [21:0] r_mapsz, n_mapsz;
    logic        r_valid, n_valid;
    tga_pkg::t_result r_res, n_res;

    logic [2:0]  ph;
    logic [4:0]  hc;
    logic [7:0]  idl, mpp, typ, mbt, bpp;
    logic [15:0] mc, w, h;
    logic [2:0]  nbytes;
    logic [31:0] left, sumdone;
    logic [7:0]  rr, gg, bb, aa, rep;
    logic [8:0]  rep9;

    always_comb begin
        ph  = i_file_start ? PH_HEADER : r_phase;
        hc  = i_file_start ? 5'd0 : r_hcnt;
        idl = i_file_start ? 8'd0 : r_idlen;
        mpp = i_file_start ? 8'd0 : r_mapp;
        typ = i_file_start ? 8'd0 : r_type;
        mc  = i_file_start ? 16'd0 : r_mcnt;
        mbt = i_file_start ? 8'd0 : r_mbits;
        w   = i_file_start ? 16'd0 : r_w;
        h   = i_file_start ? 16'd0 : r_h;
        bpp = i_file_start ? 8'd0 : r_bpp;
        n_phase = ph; n_hcnt = hc; n_idlen = idl; n_mapp = mpp; n_type = typ;
        n_mcnt = mc; n_mbits = mbt; n_w = w; n_h = h; n_bpp = bpp;
        n_skip = r_skip; n_pix = r_pix; n_bpos = r_bpos; n_prem = r_prem;
        n_isrun = r_isrun; n_done = r_done;
        n_total = r_total; n_mapsz = r_mapsz;
        n_valid = 1'b0;
        n_res = '0;
        nbytes = bpp[5:3];
        left = r_total - r_done;
        rr = '0; gg = '0; bb = '0; aa = '0; rep = 8'd1; rep9 = '0;
        sumdone = '0;
        if (i_valid) begin
            n_res.image_width = w;
            n_res.image_height = h;
            unique case (ph)
                PH_HEADER: begin
                    unique case (hc)
                        5'd0:  n_idlen = i_data_byte;
                        5'd1:  n_mapp = i_data_byte;
                        5'd2:  n_type = i_data_byte;
                        5'd5:  n_mcnt = {mc[15:8], i_data_byte};
                        5'd6:  n_mcnt = {i_data_byte, mc[7:0]};
                        5'd7:  n_mbits = i_data_byte;
                        5'd12: n_w = {w[15:8], i_data_byte};
                        5'd13: n_w = {i_data_byte, w[7:0]};
                        5'd14: n_h = {h[15:8], i_data_byte};
                        5'd15: n_h = {i_data_byte, h[7:0]};
                        5'd16: n_bpp = i_data_byte;
                        default: ;
                    endcase
                    n_hcnt = hc + 5'd1;
                    // products registered on header byte 17, ready before byte 18 is taken
                    if (hc == 5'd16) begin
                        n_total = w * h;
                        n_mapsz = 22'(mc * 22'(({1'b0, mbt} + 9'd7) >> 3));
                    end
                    if (hc == 5'd17) begin
                        n_valid = 1'b1;
                        n_res.image_width = w;
                        n_res.image_height = h;
                        n_done = '0;
                        n_skip = 22'(idl) + ((mpp != 8'd0) ? r_mapsz : 22'd0);
                        n_bpos = '0; n_pix = '0; n_prem = '0; n_isrun = 1'b0;
                        if (typ != 8'd2 && typ != 8'd10) begin
                            n_phase = PH_IDLE;
                            n_res.kind = tga_pkg::KIND_BADTYP;
                            n_res.image_last = 1'b1;
                        end else if (bpp != 8'd16 && bpp != 8'd24 && bpp != 8'd32) begin
                            n_phase = PH_IDLE;
                            n_res.kind = tga_pkg::KIND_BADBPP;
                            n_res.image_last = 1'b1;
                        end else if (r_total == 32'd0) begin
                            n_phase = PH_IDLE;
                            n_res.kind = tga_pkg::KIND_HEADER;
                            n_res.image_last = 1'b1;
                        end else begin
                            n_res.kind = tga_pkg::KIND_HEADER;
                            if (n_skip != 22'd0) n_phase = PH_SKIP;
                            else n_phase = (typ == 8'd10) ? PH_PACKET : PH_PIXEL;
                        end
                    end
                end
                PH_SKIP: begin
                    if (r_skip <= 22'd1) begin
                        n_skip = '0;
                        n_bpos = '0; n_pix = '0; n_prem = '0; n_isrun = 1'b0;
                        n_phase = (typ == 8'd10) ? PH_PACKET : PH_PIXEL;
                    end else begin
                        n_skip = r_skip - 22'd1;
                    end
                end
                PH_PACKET: begin
                    n_isrun = i_data_byte[7];
                    n_prem = i_data_byte[6:0];
                    n_bpos = '0; n_pix = '0;
                    n_phase = PH_PIXEL;
                end
                PH_PIXEL: begin
                    if ({1'b0, r_bpos} + 3'd1 < nbytes) begin
                        unique case (r_bpos)
                            2'd0: n_pix[7:0] = i_data_byte;
                            2'd1: n_pix[15:8] = i_data_byte;
                            2'd2: n_pix[23:16] = i_data_byte;
                            default: ;
                        endcase
                        n_bpos = r_bpos + 2'd1;
                    end else begin
                        if (nbytes == 3'd4) begin
                            rr = r_pix[23:16]; gg = r_pix[15:8]; bb = r_pix[7:0];
                            aa = i_data_byte;
                        end else if (nbytes == 3'd3) begin
                            rr = i_data_byte; gg = r_pix[15:8]; bb = r_pix[7:0];
                        end else begin
                            rr = {i_data_byte[6:2], 3'b0};
                            gg = {i_data_byte[1:0], r_pix[7:5], 3'b0};
                            bb = {r_pix[4:0], 3'b0};
                            aa = {i_data_byte[7], 7'b0};
                        end
                        n_bpos = '0; n_pix = '0;
                        rep9 = 9'd1;
                        if (typ == 8'd10) begin
                            if (r_isrun) begin
                                rep9 = {2'b0, r_prem} + 9'd1;
                                n_phase = PH_PACKET;
                            end else if (r_prem == 7'd0) begin
                                n_phase = PH_PACKET;
                            end else begin
                                n_prem = r_prem - 7'd1;
                            end
                        end
                        if (32'(rep9) > left) rep = left[7:0];
                        else rep = rep9[7:0];
                        sumdone = r_done + 32'(rep);
                        n_done = sumdone;
                        n_valid = 1'b1;
                        n_res.kind = tga_pkg::KIND_PIXEL;
                        n_res.red = rr; n_res.green = gg; n_res.blue = bb;
                        n_res.alpha = aa;
                        n_res.repeat_count = rep;
                        n_res.pixel_index = r_done;
                        n_res.image_last = (sumdone >= r_total);
                        if (sumdone >= r_total) n_phase = PH_IDLE;
                    end
                end
                default: ;
            endcase
        end else begin
            n_phase = r_phase; n_hcnt = r_hcnt; n_idlen = r_idlen; n_mapp = r_mapp;
            n_type = r_type; n_mcnt = r_mcnt; n_mbits = r_mbits; n_w = r_w;
            n_h = r_h; n_bpp = r_bpp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER; r_hcnt <= '0; r_idlen <= '0; r_mapp <= '0;
            r_type <= '0; r_mcnt <= '0; r_mbits <= '0; r_w <= '0; r_h <= '0;
            r_bpp <= '0; r_skip <= '0; r_pix <= '0; r_bpos <= '0; r_prem <= '0;
            r_isrun <= 1'b0; r_done <= '0; r_total <= '0; r_mapsz <= '0;
            r_valid <= 1'b0;
        end else begin
            r_phase <= n_phase; r_hcnt <= n_hcnt; r_idlen <= n_idlen;
            r_mapp <= n_mapp; r_type <= n_type; r_mcnt <= n_mcnt;
            r_mbits <= n_mbits; r_w <= n_w; r_h <= n_h; r_bpp <= n_bpp;
            r_skip <= n_skip; r_pix <= n_pix; r_bpos <= n_bpos; r_prem <= n_prem;
            r_isrun <= n_isrun; r_done <= n_done; r_total <= n_total;
            r_mapsz <= n_mapsz; r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid  = r_valid;
    assign o_result = r_res;

    `TGA_ASSERT_IMP(a_phase_legal, i_clk, i_rst_n, 1'b1, r_phase <= PH_IDLE)
    `TGA_ASSERT_IMP(a_hcnt_range, i_clk, i_rst_n, r_phase == PH_HEADER, r_hcnt <= 5'd17)
    `TGA_ASSERT_NXT(a_idle_quiet, i_clk, i_rst_n,
        r_phase == PH_IDLE && !(i_valid && i_file_start), !r_valid)
endmodule

// ===== design/tga_queue.sv =====
// Result queue between decoder front end and the output side.
// Depends on tga_pkg.
`timescale 1ns / 1ps
`include "tga_image_stream_decoder_macros.svh"
module tga_queue #(
    parameter int DEPTH = tga_pkg::QueueDepth
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tga_pkg::t_result  i_word,
    input  logic              i_pop,
    output logic              o_empty,
    output logic              o_room,
    output tga_pkg::t_result  o_word
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    tga_pkg::t_result r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic do_push, do_pop;

    // room keeps two slots free for words already in the front pipeline
    assign o_room  = r_cnt + (AW+1)'(2) < (AW+1)'(DEPTH);
    assign o_empty = (r_cnt == '0);
    assign o_word  = r_mem[r_rp];
    assign do_push = i_push;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + AW'(1);
            if (do_pop)  r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end

    `TGA_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, do_push && !do_pop,
        r_cnt < (AW+1)'(DEPTH))
    `TGA_ASSERT_NXT(a_pop_moves, i_clk, i_rst_n, do_pop && !do_push,
        r_cnt == $past(r_cnt) - (AW+1)'(1))
    `TGA_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, 1'b1, r_cnt <= (AW+1)'(DEPTH))
endmodule

// ===== design/tga_image_stream_decoder.sv =====
// Top level of the TGA stream decoder: front end plus result queue.
// Depends on tga_pkg, tga_front, tga_queue.
`timescale 1ns / 1ps
// Usage:
//   Input channel: one file byte per word; drive push with full low.
//   i_file_start marks the first byte of a file and restarts the parser.
//   Result channel: a word waits while empty is low; assert pop to take it.
//   One byte is taken per word, so a word per cycle is sustained while
//   full is low; the front end parses each byte as it is taken.
//   A result is registered in the front end, then written into the queue.
//   Header byte 18 gives a header word; every final pixel byte gives a pixel
//   word, or a run word with its repeat count clamped to the image.
//   Bad type or depth gives one flag word and later bytes are ignored.
//   When the receiver stalls, results collect in a small queue and full
//   rises while two slots are left, covering words still in flight.
//   Reset empties the queue and returns the parser to the header.
module tga_image_stream_decoder #(
    parameter int QUEUE_DEPTH = tga_pkg::QueueDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_file_start,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic [7:0]  o_alpha,
    output logic [7:0]  o_repeat_count,
    output logic [31:0] o_pixel_index,
    output logic        o_image_last,
    output logic [15:0] o_image_width,
    output logic [15:0] o_image_height
);
    logic fr_valid, q_room, accept;
    tga_pkg::t_result fr_word, q_word;

    assign full   = !q_room;
    assign accept = push && q_room;

    tga_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(accept),
        .i_data_byte(i_data_byte), .i_file_start(i_file_start),
        .o_valid(fr_valid), .o_result(fr_word)
    );

    tga_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(fr_valid), .i_word(fr_word),
        .i_pop(pop), .o_empty(empty), .o_room(q_room), .o_word(q_word)
    );

    assign o_kind = q_word.kind;
    assign o_red = q_word.red;
    assign o_green = q_word.green;
    assign o_blue = q_word.blue;
    assign o_alpha = q_word.alpha;
    assign o_repeat_count = q_word.repeat_count;
    assign o_pixel_index = q_word.pixel_index;
    assign o_image_last = q_word.image_last;
    assign o_image_width = q_word.image_width;
    assign o_image_height = q_word.image_height;
endmodule
